// ===== rtl/core/rgb_crossfade_engine_assert.svh =====
// Assertion macros for the RGB cross-fade engine.
// Each expects clk and arst_n in the scope of the use.
`ifndef RGB_CROSSFADE_ENGINE_ASSERT_SVH
`define RGB_CROSSFADE_ENGINE_ASSERT_SVH

// Same-cycle implication.
`define RCE_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rce assertion failed");

// Next-cycle implication.
`define RCE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rce assertion failed");

`endif

// ===== rtl/core/rce_pkg.sv =====
// Shared types, constants and helpers for the RGB cross-fade engine.
// No dependencies.
package rce_pkg;

	localparam int FADE_STEPS_DEF = 1020;
	localparam int NUM_CH         = 3;
	localparam int LEVEL_W        = 8;
	localparam int PCT_W          = 7;
	localparam int PCT_FULL       = 100;
	localparam int LEVEL_MAX      = 255;

	// ceil(2^20 / 100): exact floor of x / 100 for any x up to 100 * 255
	localparam int PCT_RECIP      = 10486;
	localparam int PCT_RECIP_SH   = 20;

	localparam logic MODE_START = 1'b0;
	localparam logic MODE_TICK  = 1'b1;

	typedef struct packed {
		logic             mode;
		logic [PCT_W-1:0] red_percent;
		logic [PCT_W-1:0] green_percent;
		logic [PCT_W-1:0] blue_percent;
	} cmd_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] red_level;
		logic [LEVEL_W-1:0] green_level;
		logic [LEVEL_W-1:0] blue_level;
		logic [LEVEL_W-1:0] red_drive;
		logic [LEVEL_W-1:0] green_drive;
		logic [LEVEL_W-1:0] blue_drive;
		logic               fade_last;
	} pix_t;

	typedef struct packed {
		logic                start;
		logic [LEVEL_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	function automatic logic [LEVEL_W-1:0] pct_to_level(input logic [PCT_W-1:0] pct);
		logic [PCT_W-1:0] sat;
		logic [14:0]      prod;
		logic [28:0]      scaled;
		sat    = (pct > PCT_W'(PCT_FULL)) ? PCT_W'(PCT_FULL) : pct;
		prod   = 15'(sat) * 15'(LEVEL_MAX);
		scaled = 29'(prod) * 29'(PCT_RECIP);
		return LEVEL_W'(scaled >> PCT_RECIP_SH);
	endfunction

endpackage

// ===== rtl/core/rce_div.sv =====
// Restoring divider: FADE_STEPS divided by an 8-bit divisor, one bit a cycle.
// Depends on rce_pkg.
module rce_div #(
	parameter int FADE_STEPS = rce_pkg::FADE_STEPS_DEF,
	localparam int STEP_W    = $clog2(FADE_STEPS + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rce_pkg::div_req_t   req,
	output rce_pkg::div_stat_t  stat,
	output logic [STEP_W-1:0]   quotient
);

	localparam int CNT_W = $clog2(STEP_W + 1);

	logic [CNT_W-1:0]            cnt_q;
	logic                        done_q;
	logic [rce_pkg::LEVEL_W-1:0] rem_q;
	logic [rce_pkg::LEVEL_W-1:0] dvs_q;
	logic [STEP_W-1:0]           quo_q;

	logic [rce_pkg::LEVEL_W:0]   shifted;
	logic                        ge;
	logic [rce_pkg::LEVEL_W:0]   diff;

	always_comb begin
		shifted = {rem_q, quo_q[STEP_W-1]};
		ge      = shifted >= {1'b0, dvs_q};
		diff    = shifted - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (req.start) begin
				cnt_q <= CNT_W'(STEP_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= STEP_W'(FADE_STEPS);
			dvs_q <= req.divisor;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[rce_pkg::LEVEL_W-1:0] : shifted[rce_pkg::LEVEL_W-1:0];
			quo_q <= {quo_q[STEP_W-2:0], ge};
		end
	end

	assign stat.busy = (cnt_q != '0);
	assign stat.done = done_q;
	assign quotient  = quo_q;

endmodule

// ===== rtl/core/rgb_crossfade_engine.sv =====
// Top level of the RGB cross-fade engine: command decode, step sequencer, fade lanes.
// Depends on rce_pkg, rce_div and rgb_crossfade_engine_assert.svh.
//
// channel  ports                       carries
// cmd      cmd_valid, cmd_stall, cmd   start (target percents) or tick
// pix      pix_valid, pix_stall, pix   levels, drives, fade_last per tick
//
// A tick yields one transfer on pix while a fade runs.
// A start runs the shared divider for each channel in turn; it forms one step
// per channel, one quotient bit a cycle.
// cmd_stall is high while the divider works and while a result waits under pix_stall.
// Reset clears levels, steps and index, and leaves the block idle.
`include "rgb_crossfade_engine_assert.svh"

module rgb_crossfade_engine #(
	parameter int FADE_STEPS = rce_pkg::FADE_STEPS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  rce_pkg::cmd_t cmd,
	output logic          pix_valid,
	input  logic          pix_stall,
	output rce_pkg::pix_t pix
);

	localparam int STEP_W = $clog2(FADE_STEPS + 1);
	localparam int LW     = rce_pkg::LEVEL_W;
	localparam int NC     = rce_pkg::NUM_CH;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_LOAD = 3'b010,
		ST_WAIT = 3'b100
	} state_t;

	state_t              state_q;
	logic [1:0]          ch_q;
	logic                active_q;
	logic [STEP_W-1:0]   idx_q;
	logic [LW-1:0]       lev_q [NC];
	logic [LW-1:0]       tgt_q [NC];
	logic [STEP_W-1:0]   mag_q [NC];
	logic                down_q [NC];
	logic [STEP_W-1:0]   cnt_q [NC];
	logic                pix_valid_q;
	rce_pkg::pix_t       pix_q;

	rce_pkg::div_req_t   div_req;
	rce_pkg::div_stat_t  div_stat;
	logic [STEP_W-1:0]   div_quo;

	logic                accept;
	logic                tick;
	logic                start;
	logic                last;
	logic signed [LW:0]  diff;
	logic [LW:0]         diff_abs;
	logic [LW-1:0]       lev_nx [NC];
	logic [STEP_W-1:0]   cnt_nx [NC];

	rce_div #(.FADE_STEPS(FADE_STEPS)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	assign cmd_stall = (state_q != ST_IDLE) || (pix_valid_q && pix_stall);
	assign accept    = cmd_valid && !cmd_stall;
	assign start     = accept && (cmd.mode == rce_pkg::MODE_START);
	assign tick      = accept && (cmd.mode == rce_pkg::MODE_TICK) && active_q;
	assign last      = (idx_q == STEP_W'(FADE_STEPS));

	always_comb begin
		diff     = $signed({1'b0, tgt_q[ch_q]}) - $signed({1'b0, lev_q[ch_q]});
		diff_abs = diff[LW] ? (LW+1)'(-diff) : diff;
		div_req.start   = (state_q == ST_LOAD);
		div_req.divisor = diff_abs[LW-1:0];
	end

	always_comb begin
		for (int c = 0; c < NC; c++) begin
			lev_nx[c] = lev_q[c];
			cnt_nx[c] = cnt_q[c];
			if (mag_q[c] != '0) begin
				if (cnt_q[c] == '0) begin
					if (down_q[c] && lev_q[c] != '0) begin
						lev_nx[c] = lev_q[c] - LW'(1);
					end else if (!down_q[c] && lev_q[c] != LW'(rce_pkg::LEVEL_MAX)) begin
						lev_nx[c] = lev_q[c] + LW'(1);
					end
				end
				cnt_nx[c] = (cnt_q[c] == mag_q[c] - STEP_W'(1)) ? '0 : cnt_q[c] + STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ch_q     <= '0;
			active_q <= 1'b0;
			idx_q    <= '0;
			for (int c = 0; c < NC; c++) begin
				lev_q[c]  <= '0;
				mag_q[c]  <= '0;
				down_q[c] <= 1'b0;
				cnt_q[c]  <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						active_q <= 1'b0;
						ch_q     <= '0;
						state_q  <= ST_LOAD;
					end else if (tick) begin
						for (int c = 0; c < NC; c++) begin
							lev_q[c] <= lev_nx[c];
							cnt_q[c] <= cnt_nx[c];
						end
						if (last) begin
							active_q <= 1'b0;
						end else begin
							idx_q <= idx_q + STEP_W'(1);
						end
					end
				end
				ST_LOAD: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (div_stat.done) begin
						mag_q[ch_q]  <= (diff == '0) ? '0 : div_quo;
						down_q[ch_q] <= diff[LW];
						if (ch_q == 2'(NC - 1)) begin
							active_q <= 1'b1;
							idx_q    <= '0;
							for (int c = 0; c < NC; c++) begin
								cnt_q[c] <= '0;
							end
							state_q <= ST_IDLE;
						end else begin
							ch_q    <= ch_q + 2'(1);
							state_q <= ST_LOAD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			tgt_q[0] <= rce_pkg::pct_to_level(cmd.red_percent);
			tgt_q[1] <= rce_pkg::pct_to_level(cmd.green_percent);
			tgt_q[2] <= rce_pkg::pct_to_level(cmd.blue_percent);
		end
		if (tick) begin
			pix_q.red_level   <= lev_nx[0];
			pix_q.green_level <= lev_nx[1];
			pix_q.blue_level  <= lev_nx[2];
			pix_q.red_drive   <= ~lev_nx[0];
			pix_q.green_drive <= ~lev_nx[1];
			pix_q.blue_drive  <= ~lev_nx[2];
			pix_q.fade_last   <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_q <= 1'b0;
		end else if (tick) begin
			pix_valid_q <= 1'b1;
		end else if (!pix_stall) begin
			pix_valid_q <= 1'b0;
		end
	end

	assign pix_valid = pix_valid_q;
	assign pix       = pix_q;

	`RCE_ASSERT_NOW(a_stall_busy, state_q != ST_IDLE, cmd_stall)
	`RCE_ASSERT_NOW(a_done_in_wait, div_stat.done, state_q == ST_WAIT)
	`RCE_ASSERT_NOW(a_busy_in_wait, div_stat.busy, state_q == ST_WAIT)
	`RCE_ASSERT_NEXT(a_last_idle, tick && last, !active_q && pix_valid && pix.fade_last)
	`RCE_ASSERT_NEXT(a_start_fills, state_q == ST_WAIT && div_stat.done && ch_q == 2'(NC - 1),
		active_q && idx_q == '0)

endmodule
